// ===== sv/tmws_pkg.sv =====
// ----------------------------------------------------------------------------
// tmws_pkg: shared types and constants of the winding sequencer
// Holds the state codes, the power command codes, the configuration register
// indexes and the structs that move between the sequencer's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tmws_pkg;

  // Default microstep setting of the drivers.
  localparam int unsigned MICROSTEPS_DEF = 16;

  // Full steps in one motor turn.
  localparam int unsigned STEPS_PER_TURN = 200;

  // Reciprocal used to split a position into whole turns and a remainder.
  localparam int unsigned RECIP_SHIFT = 32;
  localparam int unsigned RECIP_W     = 25;
  localparam int unsigned POS_W       = 16;
  localparam int unsigned Q_W         = POS_W + RECIP_W - RECIP_SHIFT;

  // Field widths.
  localparam int unsigned TGT_W   = 17;
  localparam int unsigned CFG_W   = 27;
  localparam int unsigned CIDX_W  = 3;

  // Register reset values.
  localparam logic [26:0] REST_MS_RST     = 27'd360000;
  localparam logic [19:0] PHASE_MS_RST    = 20'd1111;
  localparam logic [14:0] WIND_TGT_RST    = 15'd28800;
  localparam logic [15:0] RUN_SPEED_RST   = 16'd240;
  localparam logic [15:0] HOME_SPEED_RST  = 16'd4000;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_BOOT        = 4'd0,
    ST_IDLE        = 4'd1,
    ST_START1      = 4'd2,
    ST_START2      = 4'd3,
    ST_START3      = 4'd4,
    ST_RUNNING     = 4'd5,
    ST_HOMING      = 4'd6,
    ST_DOOR_OPENED = 4'd7,
    ST_TRAVEL_HOME = 4'd8,
    ST_DOOR_PAUSED = 4'd9
  } state_t;

  // Driver power commands.
  typedef enum logic [1:0] {
    PWR_NONE    = 2'd0,
    PWR_DISABLE = 2'd1,
    PWR_ENABLE  = 2'd2
  } power_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_REST_MS     = 3'd0,
    REG_PHASE_MS    = 3'd1,
    REG_WIND_TARGET = 3'd2,
    REG_RUN_SPEED   = 3'd3,
    REG_HOME_SPEED  = 3'd4
  } cfg_idx_t;

  // Current configuration.
  typedef struct packed {
    logic [26:0] rest_ms;
    logic [19:0] phase_delay_ms;
    logic [14:0] wind_target_steps;
    logic [15:0] run_speed_hz;
    logic [15:0] homing_speed_hz;
  } cfg_t;

  // Decision of the sequencer for one item.
  typedef struct packed {
    state_t      state_code;
    logic [2:0]  move_mask;
    logic [14:0] run_tgt;
    logic        turn_sel;
    logic        speed_set;
    logic [15:0] speed_hz;
    power_t      power_cmd;
    logic        zero_positions;
    logic        start_homing;
  } ctrl_res_t;

endpackage

`default_nettype wire

// ===== sv/three_motor_winding_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// three_motor_winding_sequencer_unit: winding sequencer for three steppers
// Usage: one item per control tick carries the door switch, the running flag,
// the millisecond time and the three pulse counter readings. Each item gives
// exactly one result item with the next state and the commands for the
// drivers (moves with targets, speed, power, position zeroing, homing start).
// Configuration is written over the cfg_ channel (cfg_ready is always high).
// Write it only while no item is in flight; the block does not enforce this.
// Pipeline: input register, decision register with the whole-turn quotient,
// output register. The whole-turn remainder is split over two register stages.
// Throughput: one item per cycle unless out_stall holds the pipeline; the
// control state updates once per item.
// Reset: the state goes to boot, the direction to forward, the configuration
// registers to their defaults and the pipeline empties.
// Stall: when out_stall holds a result, the stages behind it fill up and
// in_stall rises once the input register cannot move on.
// ----------------------------------------------------------------------------
`default_nettype none

module three_motor_winding_sequencer_unit #(
  parameter int unsigned MICROSTEPS = tmws_pkg::MICROSTEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_door_closed,
  input  wire logic               in_any_motor_running,
  input  wire logic [31:0]        in_time_ms,
  input  wire logic signed [15:0] in_x_position,
  input  wire logic signed [15:0] in_y_position,
  input  wire logic signed [15:0] in_z_position,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [3:0]              out_state_code,
  output logic [2:0]              out_move_mask,
  output logic signed [16:0]      out_x_target,
  output logic signed [16:0]      out_y_target,
  output logic signed [16:0]      out_z_target,
  output logic                    out_speed_set,
  output logic [15:0]             out_speed_hz,
  output logic [1:0]              out_power_cmd,
  output logic                    out_zero_positions,
  output logic                    out_start_homing,
  // configuration
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [26:0]        cfg_data
);

  tmws_pkg::cfg_t      cfg;
  tmws_pkg::ctrl_res_t ctrl_res;
  tmws_pkg::ctrl_res_t s1_r;
  tmws_pkg::ctrl_res_t s2_r;
  logic                fwd;

  logic v0_r, v1_r, v2_r;
  logic rdy0, rdy1, rdy2;
  logic adv0, adv1, adv2;

  logic               d0_door_r;
  logic               d0_running_r;
  logic [31:0]        d0_time_r;
  logic signed [15:0] d0_x_r, d0_y_r, d0_z_r;

  logic [16:0] x_turn, y_turn, z_turn;
  logic [16:0] x_tgt_r, y_tgt_r, z_tgt_r;
  logic [16:0] run_tgt17;

  // Pipeline flow control: a stage moves when the one ahead is free or moving.
  always_comb begin
    rdy2 = !v2_r || !out_stall;
    rdy1 = !v1_r || rdy2;
    rdy0 = !v0_r || rdy1;
    adv2 = v1_r && rdy2;
    adv1 = v0_r && rdy1;
    adv0 = in_valid && rdy0;
  end

  assign in_stall  = !rdy0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (adv0) begin
      d0_door_r    <= in_door_closed;
      d0_running_r <= in_any_motor_running;
      d0_time_r    <= in_time_ms;
      d0_x_r       <= in_x_position;
      d0_y_r       <= in_y_position;
      d0_z_r       <= in_z_position;
    end
  end

  tmws_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg_o    (cfg)
  );

  tmws_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv1),
    .door_closed (d0_door_r),
    .any_running (d0_running_r),
    .time_ms     (d0_time_r),
    .cfg         (cfg),
    .res_o       (ctrl_res),
    .fwd_o       (fwd)
  );

  tmws_turn #(.MICROSTEPS(MICROSTEPS)) u_turn_x (
    .clk (clk), .load (adv1), .pos_i (d0_x_r), .fwd_i (fwd), .target_o (x_turn)
  );

  tmws_turn #(.MICROSTEPS(MICROSTEPS)) u_turn_y (
    .clk (clk), .load (adv1), .pos_i (d0_y_r), .fwd_i (fwd), .target_o (y_turn)
  );

  tmws_turn #(.MICROSTEPS(MICROSTEPS)) u_turn_z (
    .clk (clk), .load (adv1), .pos_i (d0_z_r), .fwd_i (fwd), .target_o (z_turn)
  );

  // Decision register.
  always_ff @(posedge clk) begin
    if (adv1) s1_r <= ctrl_res;
  end

  // Output register: pick whole-turn targets or the run target per motor.
  assign run_tgt17 = {2'b00, s1_r.run_tgt};

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_r    <= s1_r;
      x_tgt_r <= s1_r.turn_sel ? x_turn : (s1_r.move_mask[0] ? run_tgt17 : 17'd0);
      y_tgt_r <= s1_r.turn_sel ? y_turn : (s1_r.move_mask[1] ? run_tgt17 : 17'd0);
      z_tgt_r <= s1_r.turn_sel ? z_turn : (s1_r.move_mask[2] ? run_tgt17 : 17'd0);
    end
  end

  assign out_valid          = v2_r;
  assign out_state_code     = s2_r.state_code;
  assign out_move_mask      = s2_r.move_mask;
  assign out_x_target       = x_tgt_r;
  assign out_y_target       = y_tgt_r;
  assign out_z_target       = z_tgt_r;
  assign out_speed_set      = s2_r.speed_set;
  assign out_speed_hz       = s2_r.speed_hz;
  assign out_power_cmd      = s2_r.power_cmd;
  assign out_zero_positions = s2_r.zero_positions;
  assign out_start_homing   = s2_r.start_homing;

  // Homing is always followed by the first motor start.
  a_homing_next: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_start_homing) |-> (out_state_code == tmws_pkg::ST_START1))
    else $error("homing not followed by start1");

  // Enabling the drivers comes only with zeroing and a new homing.
  a_enable_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_power_cmd == tmws_pkg::PWR_ENABLE) |->
      (out_zero_positions && out_speed_set && out_state_code == tmws_pkg::ST_HOMING))
    else $error("enable without zeroing and homing");

  // A move of all three motors is the door escape and always sets the speed.
  a_escape_speed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_move_mask == 3'b111) |->
      (out_speed_set && out_state_code == tmws_pkg::ST_TRAVEL_HOME))
    else $error("three-motor move without speed change");

endmodule

`default_nettype wire

// ===== sv/tmws_cfg.sv =====
// ----------------------------------------------------------------------------
// tmws_cfg: configuration registers
// Five registers written through an index and data write channel.
// Writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module tmws_cfg (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     wr_en,
  input  wire logic [2:0]               wr_index,
  input  wire logic [26:0]              wr_data,
  output tmws_pkg::cfg_t                cfg_o
);

  tmws_pkg::cfg_t cfg_r;

  // Register file write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rest_ms           <= tmws_pkg::REST_MS_RST;
      cfg_r.phase_delay_ms    <= tmws_pkg::PHASE_MS_RST;
      cfg_r.wind_target_steps <= tmws_pkg::WIND_TGT_RST;
      cfg_r.run_speed_hz      <= tmws_pkg::RUN_SPEED_RST;
      cfg_r.homing_speed_hz   <= tmws_pkg::HOME_SPEED_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        tmws_pkg::REG_REST_MS:     cfg_r.rest_ms           <= wr_data;
        tmws_pkg::REG_PHASE_MS:    cfg_r.phase_delay_ms    <= wr_data[19:0];
        tmws_pkg::REG_WIND_TARGET: cfg_r.wind_target_steps <= wr_data[14:0];
        tmws_pkg::REG_RUN_SPEED:   cfg_r.run_speed_hz      <= wr_data[15:0];
        tmws_pkg::REG_HOME_SPEED:  cfg_r.homing_speed_hz   <= wr_data[15:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

`default_nettype wire

// ===== sv/tmws_turn.sv =====
// ----------------------------------------------------------------------------
// tmws_turn: next whole turn for one motor
// Splits a signed position into turns and remainder with a reciprocal
// multiply, registers it, then corrects the remainder and forms the target.
// ----------------------------------------------------------------------------
`default_nettype none

module tmws_turn #(
  parameter int unsigned MICROSTEPS = tmws_pkg::MICROSTEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               load,
  input  wire logic signed [15:0] pos_i,
  input  wire logic               fwd_i,
  output logic [16:0]             target_o
);

  localparam int unsigned RW   = tmws_pkg::RECIP_W;
  localparam int unsigned QW   = tmws_pkg::Q_W;
  localparam int unsigned PW   = tmws_pkg::POS_W + RW;
  localparam int unsigned REV  = tmws_pkg::STEPS_PER_TURN * MICROSTEPS;
  localparam logic [RW-1:0] RECIP = RW'((64'd1 << tmws_pkg::RECIP_SHIFT) / REV);
  localparam logic [16:0] REV17 = 17'(REV);
  localparam logic [18:0] REV19 = 19'(REV);

  logic          neg;
  logic [15:0]   mag;
  logic [PW-1:0] prod;

  logic signed [15:0] pos_r;
  logic               neg_r;
  logic [15:0]        mag_r;
  logic [QW-1:0]      q_r;
  logic               fwd_r;

  logic [31:0]        qrev;
  logic [16:0]        rem_raw;
  logic [16:0]        rem;
  logic signed [18:0] rem_s;
  logic signed [18:0] pos19;
  logic signed [18:0] tgt19;

  // Magnitude and estimated turn count (may be one low).
  always_comb begin
    neg  = pos_i[15];
    mag  = neg ? 16'(-pos_i) : 16'(pos_i);
    prod = PW'(mag) * PW'(RECIP);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pos_r <= pos_i;
      neg_r <= neg;
      mag_r <= mag;
      q_r   <= prod[PW-1:tmws_pkg::RECIP_SHIFT];
      fwd_r <= fwd_i;
    end
  end

  // Remainder with one correction step, then the turn boundary ahead or behind.
  always_comb begin
    qrev    = 32'(q_r) * 32'(REV);
    rem_raw = {1'b0, mag_r} - qrev[16:0];
    rem     = (rem_raw >= REV17) ? (rem_raw - REV17) : rem_raw;
    rem_s   = neg_r ? -$signed({2'b00, rem}) : $signed({2'b00, rem});
    pos19   = {{3{pos_r[15]}}, pos_r};
    tgt19   = fwd_r ? (pos19 + $signed(REV19) - rem_s) : (pos19 - rem_s);
  end

  assign target_o = tgt19[16:0];

endmodule

`default_nettype wire

// ===== sv/tmws_ctrl.sv =====
// ----------------------------------------------------------------------------
// tmws_ctrl: sequencer state and per-item decision
// Holds the present and pending states, the state-entry time and flag and the
// run direction, and decides the commands for the item in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module tmws_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           adv,
  input  wire logic           door_closed,
  input  wire logic           any_running,
  input  wire logic [31:0]    time_ms,
  input  wire tmws_pkg::cfg_t cfg,
  output tmws_pkg::ctrl_res_t res_o,
  output logic                fwd_o
);

  tmws_pkg::state_t present_r, pending_r;
  tmws_pkg::state_t pend_mid, pending_nxt;
  logic             entry_flag_r;
  logic [31:0]      entry_time_r, entry_time_nxt;
  logic             fwd_r, fwd_nxt;
  logic             door_trip;
  logic             changed;
  logic             entry_now;
  logic [31:0]      elapsed;
  logic             rest_done;
  logic             phase_done;

  // State entry bookkeeping and the door check ahead of the state logic.
  always_comb begin
    door_trip = !door_closed &&
                (present_r != tmws_pkg::ST_DOOR_OPENED) &&
                (present_r != tmws_pkg::ST_TRAVEL_HOME) &&
                (present_r != tmws_pkg::ST_DOOR_PAUSED);
    pend_mid       = door_trip ? tmws_pkg::ST_DOOR_OPENED : pending_r;
    changed        = (present_r != pend_mid);
    entry_time_nxt = changed ? time_ms : entry_time_r;
    entry_now      = changed || entry_flag_r;
    elapsed        = time_ms - entry_time_nxt;
    rest_done      = elapsed > {5'd0, cfg.rest_ms};
    phase_done     = elapsed > {12'd0, cfg.phase_delay_ms};
  end

  // Next state and commands.
  always_comb begin
    pending_nxt          = pend_mid;
    fwd_nxt              = fwd_r;
    res_o                = '0;
    res_o.power_cmd      = tmws_pkg::PWR_NONE;
    res_o.run_tgt        = fwd_r ? cfg.wind_target_steps : 15'd0;
    unique case (pend_mid)
      tmws_pkg::ST_IDLE: begin
        if (rest_done) pending_nxt = tmws_pkg::ST_START1;
      end
      tmws_pkg::ST_START1: begin
        if (entry_now) res_o.move_mask = 3'b001;
        if (phase_done) pending_nxt = tmws_pkg::ST_START2;
      end
      tmws_pkg::ST_START2: begin
        if (entry_now) res_o.move_mask = 3'b010;
        if (phase_done) pending_nxt = tmws_pkg::ST_START3;
      end
      tmws_pkg::ST_START3: begin
        if (entry_now) res_o.move_mask = 3'b100;
        if (phase_done) pending_nxt = tmws_pkg::ST_RUNNING;
      end
      tmws_pkg::ST_RUNNING: begin
        if (!any_running) begin
          fwd_nxt     = !fwd_r;
          pending_nxt = tmws_pkg::ST_IDLE;
        end
      end
      tmws_pkg::ST_HOMING: begin
        res_o.start_homing = 1'b1;
        pending_nxt        = tmws_pkg::ST_START1;
      end
      tmws_pkg::ST_DOOR_OPENED: begin
        if (any_running) begin
          res_o.speed_set = 1'b1;
          res_o.speed_hz  = cfg.homing_speed_hz;
          res_o.move_mask = 3'b111;
          res_o.turn_sel  = 1'b1;
        end
        pending_nxt = tmws_pkg::ST_TRAVEL_HOME;
      end
      tmws_pkg::ST_TRAVEL_HOME: begin
        if (!any_running) pending_nxt = tmws_pkg::ST_DOOR_PAUSED;
      end
      tmws_pkg::ST_DOOR_PAUSED: begin
        if (entry_now) res_o.power_cmd = tmws_pkg::PWR_DISABLE;
        // Door already shut again: enable wins over the disable of this item.
        if (door_closed) begin
          res_o.power_cmd      = tmws_pkg::PWR_ENABLE;
          res_o.zero_positions = 1'b1;
          res_o.speed_set      = 1'b1;
          res_o.speed_hz       = cfg.run_speed_hz;
          fwd_nxt              = 1'b1;
          pending_nxt          = tmws_pkg::ST_HOMING;
        end
      end
      tmws_pkg::ST_BOOT: begin
        pending_nxt = tmws_pkg::ST_HOMING;
      end
      default: begin
        pending_nxt = tmws_pkg::ST_HOMING;
      end
    endcase
    res_o.state_code = pending_nxt;
  end

  // State registers advance once per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r    <= tmws_pkg::ST_BOOT;
      pending_r    <= tmws_pkg::ST_BOOT;
      entry_flag_r <= 1'b1;
      entry_time_r <= 32'd0;
      fwd_r        <= 1'b1;
    end else if (adv) begin
      present_r    <= pend_mid;
      pending_r    <= pending_nxt;
      entry_flag_r <= 1'b0;
      entry_time_r <= entry_time_nxt;
      fwd_r        <= fwd_nxt;
    end
  end

  assign fwd_o = fwd_r;

  // The entry flag only survives until the first item after reset.
  a_entry_flag_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> !entry_flag_r)
    else $error("entry flag still set after an item");

  // Closing the door from the pause always restores forward winding.
  a_door_close_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && pend_mid == tmws_pkg::ST_DOOR_PAUSED && door_closed) |=> fwd_r)
    else $error("direction not forward after door close");

endmodule

`default_nettype wire

// ===== tb/sv/three_motor_winding_sequencer_checker.sv =====
// ----------------------------------------------------------------------------
// Winding sequencer checker
// Watches the item, result and configuration channels of the winding
// sequencer. It keeps its own copy of the sequencer state and registers,
// works out the expected command set for every accepted item and compares
// each accepted result with the oldest expectation, field by field.
// ----------------------------------------------------------------------------
module three_motor_winding_sequencer_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic                in_door_closed,
  input  logic                in_any_motor_running,
  input  logic [31:0]         in_time_ms,
  input  logic signed [15:0]  in_x_position,
  input  logic signed [15:0]  in_y_position,
  input  logic signed [15:0]  in_z_position,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [3:0]          out_state_code,
  input  logic [2:0]          out_move_mask,
  input  logic signed [16:0]  out_x_target,
  input  logic signed [16:0]  out_y_target,
  input  logic signed [16:0]  out_z_target,
  input  logic                out_speed_set,
  input  logic [15:0]         out_speed_hz,
  input  logic [1:0]          out_power_cmd,
  input  logic                out_zero_positions,
  input  logic                out_start_homing,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [26:0]         cfg_data,
  output int                  mismatch_count,
  output int                  results_waiting,
  output int                  results_seen
);

  // Microsteps in one full motor turn.
  localparam int TURN_STEPS = tmws_pkg::STEPS_PER_TURN * tmws_pkg::MICROSTEPS_DEF;

  // Commands the sequencer issues for one item.
  typedef struct packed {
    logic [3:0]         state_code;
    logic [2:0]         move_mask;
    logic signed [16:0] x_target;
    logic signed [16:0] y_target;
    logic signed [16:0] z_target;
    logic               speed_set;
    logic [15:0]        speed_hz;
    logic [1:0]         power_cmd;
    logic               zero_positions;
    logic               start_homing;
  } winding_cmd_t;

  // Register copies.
  logic [26:0] rest_lim;
  logic [19:0] phase_lim;
  logic [14:0] wind_steps;
  logic [15:0] run_hz;
  logic [15:0] home_hz;

  // Sequencer state copy.
  tmws_pkg::state_t seq_state;
  tmws_pkg::state_t next_state;
  logic             entry_pending;
  logic [31:0]      entry_ms;
  logic             forward;

  winding_cmd_t expected_cmds[$];
  winding_cmd_t oldest;

  // Next whole turn from a position, in the given direction.
  function automatic logic signed [16:0] whole_turn_target(input logic signed [15:0] pos,
                                                           input logic fwd);
    int p;
    int r;
    p = pos;
    r = p % TURN_STEPS;
    if (fwd) begin
      return 17'(p + TURN_STEPS - r);
    end
    return 17'(p - r);
  endfunction

  // Advance the state copy by one item and queue the commands it gives.
  task automatic predict_winding_tick(input logic door, input logic running,
                                      input logic [31:0] now,
                                      input logic signed [15:0] xp,
                                      input logic signed [15:0] yp,
                                      input logic signed [15:0] zp);
    winding_cmd_t cmd;
    logic [31:0] elapsed;
    logic signed [16:0] run_target;
    cmd = '0;
    // An open door preempts every state outside the door sequence.
    if (!door && seq_state != tmws_pkg::ST_DOOR_OPENED &&
        seq_state != tmws_pkg::ST_TRAVEL_HOME &&
        seq_state != tmws_pkg::ST_DOOR_PAUSED) begin
      next_state = tmws_pkg::ST_DOOR_OPENED;
    end
    if (seq_state != next_state) begin
      entry_ms = now;
      entry_pending = 1'b1;
    end
    seq_state = next_state;
    elapsed = now - entry_ms;
    run_target = forward ? {2'b00, wind_steps} : '0;

    case (seq_state)
      tmws_pkg::ST_IDLE: begin
        if (elapsed > rest_lim) next_state = tmws_pkg::ST_START1;
      end
      tmws_pkg::ST_START1, tmws_pkg::ST_START2, tmws_pkg::ST_START3: begin
        // Each start state issues its one motor move on entry.
        if (entry_pending) begin
          case (seq_state)
            tmws_pkg::ST_START1: begin
              cmd.move_mask = 3'b001;
              cmd.x_target = run_target;
            end
            tmws_pkg::ST_START2: begin
              cmd.move_mask = 3'b010;
              cmd.y_target = run_target;
            end
            default: begin
              cmd.move_mask = 3'b100;
              cmd.z_target = run_target;
            end
          endcase
        end
        if (elapsed > phase_lim) begin
          next_state = (seq_state == tmws_pkg::ST_START1) ? tmws_pkg::ST_START2 :
                       (seq_state == tmws_pkg::ST_START2) ? tmws_pkg::ST_START3 :
                       tmws_pkg::ST_RUNNING;
        end
      end
      tmws_pkg::ST_RUNNING: begin
        if (!running) begin
          forward = !forward;
          next_state = tmws_pkg::ST_IDLE;
        end
      end
      tmws_pkg::ST_HOMING: begin
        cmd.start_homing = 1'b1;
        next_state = tmws_pkg::ST_START1;
      end
      tmws_pkg::ST_DOOR_OPENED: begin
        // Moving motors are sped up and sent to the next whole turn.
        if (running) begin
          cmd.speed_set = 1'b1;
          cmd.speed_hz = home_hz;
          cmd.move_mask = 3'b111;
          cmd.x_target = whole_turn_target(xp, forward);
          cmd.y_target = whole_turn_target(yp, forward);
          cmd.z_target = whole_turn_target(zp, forward);
        end
        next_state = tmws_pkg::ST_TRAVEL_HOME;
      end
      tmws_pkg::ST_TRAVEL_HOME: begin
        if (!running) next_state = tmws_pkg::ST_DOOR_PAUSED;
      end
      tmws_pkg::ST_DOOR_PAUSED: begin
        // Enable wins over the entry disable when the door is already shut.
        if (entry_pending) cmd.power_cmd = tmws_pkg::PWR_DISABLE;
        if (door) begin
          cmd.power_cmd = tmws_pkg::PWR_ENABLE;
          cmd.zero_positions = 1'b1;
          cmd.speed_set = 1'b1;
          cmd.speed_hz = run_hz;
          forward = 1'b1;
          next_state = tmws_pkg::ST_HOMING;
        end
      end
      default: begin
        next_state = tmws_pkg::ST_HOMING;
      end
    endcase
    entry_pending = 1'b0;
    cmd.state_code = next_state;
    expected_cmds.push_back(cmd);
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Channel monitor: results are retired before new items are predicted, so a
  // stray result is never matched against an item accepted on the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      rest_lim = tmws_pkg::REST_MS_RST;
      phase_lim = tmws_pkg::PHASE_MS_RST;
      wind_steps = tmws_pkg::WIND_TGT_RST;
      run_hz = tmws_pkg::RUN_SPEED_RST;
      home_hz = tmws_pkg::HOME_SPEED_RST;
      seq_state = tmws_pkg::ST_BOOT;
      next_state = tmws_pkg::ST_BOOT;
      entry_pending = 1'b1;
      entry_ms = '0;
      forward = 1'b1;
      expected_cmds.delete();
      mismatch_count = 0;
      results_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tmws_pkg::REG_REST_MS:     rest_lim = cfg_data;
          tmws_pkg::REG_PHASE_MS:    phase_lim = cfg_data[19:0];
          tmws_pkg::REG_WIND_TARGET: wind_steps = cfg_data[14:0];
          tmws_pkg::REG_RUN_SPEED:   run_hz = cfg_data[15:0];
          tmws_pkg::REG_HOME_SPEED:  home_hz = cfg_data[15:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_cmds.size() == 0) begin
          $error("result item with state_code %0d arrived with nothing expected",
                 out_state_code);
          mismatch_count++;
        end else begin
          oldest = expected_cmds.pop_front();
          compare_field("state_code", oldest.state_code, out_state_code);
          compare_field("move_mask", oldest.move_mask, out_move_mask);
          compare_field("x_target", oldest.x_target, out_x_target);
          compare_field("y_target", oldest.y_target, out_y_target);
          compare_field("z_target", oldest.z_target, out_z_target);
          compare_field("speed_set", oldest.speed_set, out_speed_set);
          compare_field("speed_hz", oldest.speed_hz, out_speed_hz);
          compare_field("power_cmd", oldest.power_cmd, out_power_cmd);
          compare_field("zero_positions", oldest.zero_positions, out_zero_positions);
          compare_field("start_homing", oldest.start_homing, out_start_homing);
        end
      end

      if (in_valid && !in_stall) begin
        predict_winding_tick(in_door_closed, in_any_motor_running, in_time_ms,
                             in_x_position, in_y_position, in_z_position);
      end
    end
    results_waiting = expected_cmds.size();
  end

endmodule

// ===== tb/sv/three_motor_winding_sequencer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Winding sequencer testbench
// Drives control ticks into the sequencer: a directed walk through homing,
// the staggered starts, a full run, the rest, the door sequence and time
// wrap, then phases of shaped random ticks under several register settings
// and idling patterns. A checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module three_motor_winding_sequencer_unit_tb;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int SETTLE_CYCLES   = 8;
  localparam int RUN_LIMIT       = 2000000;
  localparam int TURN_STEPS      = tmws_pkg::STEPS_PER_TURN * tmws_pkg::MICROSTEPS_DEF;

  // Register range limits.
  localparam logic [26:0] REST_MAX  = 27'd86400000;
  localparam logic [19:0] PHASE_MAX = 20'd600000;
  localparam logic [14:0] WIND_MAX  = 15'd32767;
  localparam logic [15:0] SPEED_MAX = 16'hFFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_door_closed = 1'b1;
  logic               in_any_motor_running = 1'b0;
  logic [31:0]        in_time_ms = '0;
  logic signed [15:0] in_x_position = '0;
  logic signed [15:0] in_y_position = '0;
  logic signed [15:0] in_z_position = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [3:0]         out_state_code;
  logic [2:0]         out_move_mask;
  logic signed [16:0] out_x_target;
  logic signed [16:0] out_y_target;
  logic signed [16:0] out_z_target;
  logic               out_speed_set;
  logic [15:0]        out_speed_hz;
  logic [1:0]         out_power_cmd;
  logic               out_zero_positions;
  logic               out_start_homing;

  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [26:0]        cfg_data = '0;

  int mismatch_count;
  int results_waiting;
  int results_seen;

  // Stimulus shaping.
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          items_sent = 0;
  int          door_openings = 0;
  logic [26:0] rest_now = tmws_pkg::REST_MS_RST;
  logic [19:0] phase_now = tmws_pkg::PHASE_MS_RST;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  three_motor_winding_sequencer_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_door_closed(in_door_closed), .in_any_motor_running(in_any_motor_running),
    .in_time_ms(in_time_ms),
    .in_x_position(in_x_position), .in_y_position(in_y_position),
    .in_z_position(in_z_position),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_state_code(out_state_code), .out_move_mask(out_move_mask),
    .out_x_target(out_x_target), .out_y_target(out_y_target),
    .out_z_target(out_z_target),
    .out_speed_set(out_speed_set), .out_speed_hz(out_speed_hz),
    .out_power_cmd(out_power_cmd), .out_zero_positions(out_zero_positions),
    .out_start_homing(out_start_homing),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  three_motor_winding_sequencer_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_door_closed(in_door_closed), .in_any_motor_running(in_any_motor_running),
    .in_time_ms(in_time_ms),
    .in_x_position(in_x_position), .in_y_position(in_y_position),
    .in_z_position(in_z_position),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_state_code(out_state_code), .out_move_mask(out_move_mask),
    .out_x_target(out_x_target), .out_y_target(out_y_target),
    .out_z_target(out_z_target),
    .out_speed_set(out_speed_set), .out_speed_hz(out_speed_hz),
    .out_power_cmd(out_power_cmd), .out_zero_positions(out_zero_positions),
    .out_start_homing(out_start_homing),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatch_count(mismatch_count), .results_waiting(results_waiting),
    .results_seen(results_seen)
  );

  // Receiver backpressure, redrawn every cycle.
  always @(negedge clk) begin
    out_stall = (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Offer one item, with random idle cycles ahead of it, and hold it until taken.
  task automatic send_item(input logic door, input logic running, input logic [31:0] now,
                           input logic signed [15:0] xp, input logic signed [15:0] yp,
                           input logic signed [15:0] zp);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_door_closed = door;
    in_any_motor_running = running;
    in_time_ms = now;
    in_x_position = xp;
    in_y_position = yp;
    in_z_position = zp;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  // Hold off the sender until every expected result is back, then settle.
  task automatic wait_drained();
    in_valid = 1'b0;
    while (results_waiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [26:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Register settings: low extremes, high extremes, mixed and random.
  task automatic load_setting(input int phase);
    logic [26:0] rest;
    logic [19:0] pdel;
    logic [14:0] wind;
    logic [15:0] run_speed;
    logic [15:0] home_speed;
    int unused_idx;
    rest = 27'($urandom_range(6000));
    pdel = 20'($urandom_range(1500));
    wind = 15'($urandom);
    run_speed = 16'($urandom);
    home_speed = 16'($urandom);
    case (phase)
      0: begin
        rest = '0;
        pdel = '0;
        wind = '0;
        run_speed = '0;
        home_speed = '0;
      end
      1: begin
        rest = REST_MAX;
        pdel = PHASE_MAX;
        wind = WIND_MAX;
        run_speed = SPEED_MAX;
        home_speed = SPEED_MAX;
      end
      2: begin
        // Writes to unassigned indexes must leave every register alone.
        for (unused_idx = tmws_pkg::REG_HOME_SPEED + 1; unused_idx <= 3'(-1);
             unused_idx++) begin
          write_reg(3'(unused_idx), 27'($urandom));
        end
      end
      5: begin
        rest = '0;
        pdel = PHASE_MAX;
      end
      6: begin
        rest = REST_MAX;
        pdel = '0;
      end
      default: ;
    endcase
    write_reg(tmws_pkg::REG_REST_MS, rest);
    write_reg(tmws_pkg::REG_PHASE_MS, 27'(pdel));
    write_reg(tmws_pkg::REG_WIND_TARGET, 27'(wind));
    write_reg(tmws_pkg::REG_RUN_SPEED, 27'(run_speed));
    write_reg(tmws_pkg::REG_HOME_SPEED, 27'(home_speed));
    rest_now = rest;
    phase_now = pdel;
  endtask

  // Time advance: mostly small, often right at a timer limit, sometimes huge.
  function automatic logic [31:0] pick_time_step();
    logic [31:0] lim;
    logic [31:0] step;
    lim = $urandom_range(1) ? 32'(rest_now) : 32'(phase_now);
    case ($urandom_range(9))
      0:       step = '0;
      1:       step = 32'd1;
      2, 3:    step = $urandom_range(20);
      4:       step = lim - 1;
      5:       step = lim;
      6:       step = lim + 1;
      7:       step = $urandom_range(lim + 50);
      8:       step = $urandom;
      default: step = lim + $urandom_range(100);
    endcase
    return step;
  endfunction

  // Positions: extremes, whole turns and their neighbors, or anything.
  function automatic logic signed [15:0] pick_position();
    logic signed [15:0] pos;
    case ($urandom_range(7))
      0: pos = 16'sh8000;
      1: pos = 16'sh7FFF;
      2: pos = '0;
      3, 4: pos = 16'(TURN_STEPS * int'($urandom_range(20)) - 32000 +
                      int'($urandom_range(2)) - 1);
      default: pos = 16'($urandom);
    endcase
    return pos;
  endfunction

  // Run limit.
  initial begin
    #(RUN_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus.
  initial begin
    logic [31:0] clock_ms;
    logic        door_now;
    logic        run_now;
    logic        noise;
    int          door_left;
    int          run_left;
    int          phase;
    int          n;

    door_now = 1'b1;
    run_now = 1'b0;
    door_left = 20;
    run_left = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed walk with the reset register values: boot, homing, the three
    // staggered starts (one tick at the exact phase delay), a run, the rest
    // at its exact limit and a backward start.
    send_item(1'b1, 1'b0, 32'd0, 16'sd0, 16'sd0, 16'sd0);
    send_item(1'b1, 1'b0, 32'd5, 16'sd0, 16'sd0, 16'sd0);
    send_item(1'b1, 1'b0, 32'd10, 16'sd0, 16'sd0, 16'sd0);
    send_item(1'b1, 1'b0, 32'd1121, 16'sd0, 16'sd0, 16'sd0);
    send_item(1'b1, 1'b0, 32'd1122, 16'sd0, 16'sd0, 16'sd0);
    send_item(1'b1, 1'b1, 32'd1200, 16'sd100, 16'sd0, 16'sd0);
    send_item(1'b1, 1'b1, 32'd2400, 16'sd200, 16'sd100, 16'sd0);
    send_item(1'b1, 1'b1, 32'd2500, 16'sd300, 16'sd200, 16'sd100);
    send_item(1'b1, 1'b1, 32'd3700, 16'sd400, 16'sd300, 16'sd200);
    send_item(1'b1, 1'b1, 32'd3800, 16'sd500, 16'sd400, 16'sd300);
    send_item(1'b1, 1'b0, 32'd3900, 16'sd28800, 16'sd28800, 16'sd28800);
    send_item(1'b1, 1'b0, 32'd4000, 16'sd28800, 16'sd28800, 16'sd28800);
    send_item(1'b1, 1'b0, 32'd364000, 16'sd28800, 16'sd28800, 16'sd28800);
    send_item(1'b1, 1'b0, 32'd364001, 16'sd28800, 16'sd28800, 16'sd28800);
    send_item(1'b1, 1'b1, 32'd364010, 16'sd28800, 16'sd28800, 16'sd28800);
    // Door opens while the motors run: whole-turn targets at the position
    // extremes and on an exact turn boundary.
    send_item(1'b0, 1'b1, 32'd364020, 16'sh8000, 16'sh7FFF, -16'sd3200);
    send_item(1'b0, 1'b1, 32'd364030, 16'sd1, -16'sd1, 16'sd0);
    send_item(1'b0, 1'b0, 32'd364040, 16'sd0, 16'sd0, 16'sd0);
    send_item(1'b0, 1'b0, 32'd364050, 16'sd0, 16'sd0, 16'sd0);
    send_item(1'b0, 1'b0, 32'd364060, 16'sd0, 16'sd0, 16'sd0);
    send_item(1'b1, 1'b0, 32'd364070, 16'sd0, 16'sd0, 16'sd0);
    send_item(1'b1, 1'b0, 32'd364080, 16'sd0, 16'sd0, 16'sd0);
    // Door opens with every motor idle, time wraps, and the pause is entered
    // with the door already closed again.
    send_item(1'b0, 1'b0, 32'hFFFF_FFF0, 16'sd0, 16'sd0, 16'sd0);
    send_item(1'b1, 1'b0, 32'hFFFF_FFFF, 16'sd0, 16'sd0, 16'sd0);
    send_item(1'b1, 1'b0, 32'd5, 16'sd0, 16'sd0, 16'sd0);
    clock_ms = 32'd5;

    // Random phases, each with its own register setting and idling pattern.
    for (phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      load_setting(phase);
      case (phase % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 51;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 51;
        end
        default: begin
          idle_pct = 33;
          stall_pct = 33;
        end
      endcase

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(199) == 0) wait_drained();

        // Door stays shut for long stretches and opens for short ones.
        if (door_left == 0) begin
          door_now = !door_now;
          door_left = door_now ? $urandom_range(50, 4) : $urandom_range(8, 1);
          if (!door_now) door_openings++;
        end
        door_left--;
        // Motors report running in short held runs.
        if (run_left == 0) begin
          run_now = $urandom_range(1);
          run_left = $urandom_range(6, 1);
        end
        run_left--;

        // A fifth of the ticks carry uncorrelated switch levels.
        noise = ($urandom_range(9) < 2);
        clock_ms = clock_ms + pick_time_step();
        send_item(noise ? 1'($urandom_range(1)) : door_now,
                  noise ? 1'($urandom_range(1)) : run_now,
                  clock_ms, pick_position(), pick_position(), pick_position());
      end
    end

    idle_pct = 0;
    stall_pct = 0;
    wait_drained();

    $display("Sent %0d items and checked %0d results over %0d register settings,",
             items_sent, results_seen, PHASES);
    $display("with %0d door openings and four idling patterns.", door_openings);
    if (mismatch_count == 0 && results_waiting == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
